// File: rtl/xmad_pkg.sv
// shared types and codes for the mov/add instruction pre-decoder
package xmad_pkg;

  // instruction form codes
  localparam logic [2:0] FORM_MOV_RM      = 3'd0;
  localparam logic [2:0] FORM_MOV_IMM_RM  = 3'd1;
  localparam logic [2:0] FORM_MOV_IMM_REG = 3'd2;
  localparam logic [2:0] FORM_ADD_RM      = 3'd3;
  localparam logic [2:0] FORM_UNKNOWN     = 3'd4;

  // opcode match masks and patterns
  localparam logic [7:0] MASK_MOV_RM      = 8'b1111_1000;
  localparam logic [7:0] PAT_MOV_RM       = 8'b1000_1000;
  localparam logic [7:0] MASK_MOV_IMM_RM  = 8'b1111_1110;
  localparam logic [7:0] PAT_MOV_IMM_RM   = 8'b1100_0110;
  localparam logic [7:0] MASK_MOV_IMM_REG = 8'b1111_0000;
  localparam logic [7:0] PAT_MOV_IMM_REG  = 8'b1011_0000;
  localparam logic [7:0] MASK_ADD_RM      = 8'b1111_1100;
  localparam logic [7:0] PAT_ADD_RM       = 8'b0000_0000;

  // mod field codes
  localparam logic [1:0] MOD_NO_DISP  = 2'd0;
  localparam logic [1:0] MOD_DISP8    = 2'd1;
  localparam logic [1:0] MOD_DISP16   = 2'd2;
  localparam logic [1:0] MOD_REGISTER = 2'd3;

  // r/m code that means a direct address under mod 00
  localparam logic [2:0] RM_DIRECT = 3'd6;

  // one decoded instruction word
  typedef struct packed {
    logic [2:0]         form;
    logic               to_register;
    logic               wide;
    logic [1:0]         mode;
    logic [2:0]         register_field;
    logic [2:0]         memory_field;
    logic               direct_address;
    logic signed [15:0] displacement;
    logic [15:0]        immediate;
    logic [2:0]         length;
  } decode_t;

endpackage

// File: rtl/xmad_decode.sv
// combinational decode of one six-byte instruction window
module xmad_decode (
  input  logic [7:0]       b0,
  input  logic [7:0]       b1,
  input  logic [7:0]       b2,
  input  logic [7:0]       b3,
  input  logic [7:0]       b4,
  input  logic [7:0]       b5,
  output xmad_pkg::decode_t dec
);

  logic [1:0]  mode;
  logic [2:0]  reg_f;
  logic [2:0]  rm;
  logic        direct;
  logic [15:0] disp;
  logic [1:0]  disp_bytes;
  logic [15:0] imm_rm;

  // mod reg r/m fields and displacement
  always_comb begin
    mode   = b1[7:6];
    reg_f  = b1[5:3];
    rm     = b1[2:0];
    direct = (mode == xmad_pkg::MOD_NO_DISP) && (rm == xmad_pkg::RM_DIRECT);
    disp       = 16'd0;
    disp_bytes = 2'd0;
    if (mode == xmad_pkg::MOD_DISP8) begin
      disp       = {{8{b2[7]}}, b2};
      disp_bytes = 2'd1;
    end else if (mode == xmad_pkg::MOD_DISP16 || direct) begin
      disp       = {b3, b2};
      disp_bytes = 2'd2;
    end
  end

  // data of mov immediate to r/m follows the displacement
  always_comb begin
    case (disp_bytes)
      2'd1:    imm_rm = {b4, b3};
      2'd2:    imm_rm = {b5, b4};
      default: imm_rm = {b3, b2};
    endcase
    if (!b0[0]) begin
      imm_rm[15:8] = 8'd0;
    end
  end

  // form select
  always_comb begin
    dec = '0;
    if ((b0 & xmad_pkg::MASK_MOV_RM) == xmad_pkg::PAT_MOV_RM) begin
      dec.form           = xmad_pkg::FORM_MOV_RM;
      dec.to_register    = b0[1];
      dec.wide           = b0[0];
      dec.mode           = mode;
      dec.register_field = reg_f;
      dec.memory_field   = rm;
      dec.direct_address = direct;
      dec.displacement   = disp;
      dec.length         = 3'd2 + {1'b0, disp_bytes};
    end else if ((b0 & xmad_pkg::MASK_MOV_IMM_RM) == xmad_pkg::PAT_MOV_IMM_RM) begin
      dec.form           = xmad_pkg::FORM_MOV_IMM_RM;
      dec.wide           = b0[0];
      dec.mode           = mode;
      dec.register_field = reg_f;
      dec.memory_field   = rm;
      dec.direct_address = direct;
      dec.displacement   = disp;
      dec.immediate      = imm_rm;
      dec.length         = 3'd3 + {1'b0, disp_bytes} + {2'b00, b0[0]};
    end else if ((b0 & xmad_pkg::MASK_MOV_IMM_REG) == xmad_pkg::PAT_MOV_IMM_REG) begin
      dec.form           = xmad_pkg::FORM_MOV_IMM_REG;
      dec.to_register    = 1'b1;
      dec.wide           = b0[3];
      dec.register_field = b0[2:0];
      dec.immediate      = {(b0[3] ? b2 : 8'd0), b1};
      dec.length         = 3'd2 + {2'b00, b0[3]};
    end else if ((b0 & xmad_pkg::MASK_ADD_RM) == xmad_pkg::PAT_ADD_RM) begin
      dec.form           = xmad_pkg::FORM_ADD_RM;
      dec.to_register    = b0[1];
      dec.wide           = b0[0];
      dec.mode           = mode;
      dec.register_field = reg_f;
      dec.memory_field   = rm;
      dec.direct_address = direct;
      dec.displacement   = disp;
      dec.length         = 3'd2 + {1'b0, disp_bytes};
    end else begin
      dec.form = xmad_pkg::FORM_UNKNOWN;
    end
  end

endmodule

// File: rtl/x86_16_mov_add_decoder_unit.sv
// top level of the mov/add instruction pre-decoder
//
// Usage:
//   Drive the six window bytes on in_first_byte .. in_sixth_byte, opcode
//   first, and raise start. A word is taken at each rising edge where
//   start is high and busy is low. busy stays low, so one word can be
//   taken every clock cycle.
//   Each word gives exactly one decoded result on the out_ ports, marked
//   by out_valid for one cycle. The window register holds the word while
//   the decoder works on it, and the next edge loads the result register
//   and raises out_valid. Throughput is one word per cycle, set by the
//   single decode pass between those two registers.
//   The receiver cannot stall: it must take each result in the cycle
//   that out_valid is high.
//   Reset (rst_n low at a clock edge) drops any word in flight and clears
//   out_valid; no results appear until new words are taken.
//   Unknown opcodes give form 4 with length 0 and all other fields 0.
module x86_16_mov_add_decoder_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [7:0]         in_first_byte,
  input  logic [7:0]         in_second_byte,
  input  logic [7:0]         in_third_byte,
  input  logic [7:0]         in_fourth_byte,
  input  logic [7:0]         in_fifth_byte,
  input  logic [7:0]         in_sixth_byte,
  output logic               out_valid,
  output logic [2:0]         out_form,
  output logic               out_to_register,
  output logic               out_wide,
  output logic [1:0]         out_mode,
  output logic [2:0]         out_register_field,
  output logic [2:0]         out_memory_field,
  output logic               out_direct_address,
  output logic signed [15:0] out_displacement,
  output logic [15:0]        out_immediate,
  output logic [2:0]         out_length
);

  logic [7:0] win_r [6];
  logic       win_valid_r;
  logic       res_valid_r;
  xmad_pkg::decode_t dec;
  xmad_pkg::decode_t res_r;

  // the decoder never holds words off
  assign busy = 1'b0;

  // control: word valid through the two stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_valid_r <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      win_valid_r <= start && !busy;
      res_valid_r <= win_valid_r;
    end
  end

  // window register
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      win_r[0] <= in_first_byte;
      win_r[1] <= in_second_byte;
      win_r[2] <= in_third_byte;
      win_r[3] <= in_fourth_byte;
      win_r[4] <= in_fifth_byte;
      win_r[5] <= in_sixth_byte;
    end
  end

  xmad_decode u_decode (
    .b0  (win_r[0]),
    .b1  (win_r[1]),
    .b2  (win_r[2]),
    .b3  (win_r[3]),
    .b4  (win_r[4]),
    .b5  (win_r[5]),
    .dec (dec)
  );

  // result register
  always_ff @(posedge clk) begin
    if (win_valid_r) begin
      res_r <= dec;
    end
  end

  assign out_valid          = res_valid_r;
  assign out_form           = res_r.form;
  assign out_to_register    = res_r.to_register;
  assign out_wide           = res_r.wide;
  assign out_mode           = res_r.mode;
  assign out_register_field = res_r.register_field;
  assign out_memory_field   = res_r.memory_field;
  assign out_direct_address = res_r.direct_address;
  assign out_displacement   = res_r.displacement;
  assign out_immediate      = res_r.immediate;
  assign out_length         = res_r.length;

endmodule

// File: test/tb_top.sv
// self-checking testbench for the mov/add instruction pre-decoder
module tb_top;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [5:0][7:0]   window_bus = '0;
  logic              out_valid;
  logic [2:0]        out_form;
  logic              out_to_register;
  logic              out_wide;
  logic [1:0]        out_mode;
  logic [2:0]        out_register_field;
  logic [2:0]        out_memory_field;
  logic              out_direct_address;
  logic signed [15:0] out_displacement;
  logic [15:0]       out_immediate;
  logic [2:0]        out_length;

  xmad_pkg::decode_t expected_decodes[$];
  int      mismatch_count = 0;
  bit      gaps_on = 1'b1;

  x86_16_mov_add_decoder_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_first_byte      (window_bus[0]),
    .in_second_byte     (window_bus[1]),
    .in_third_byte      (window_bus[2]),
    .in_fourth_byte     (window_bus[3]),
    .in_fifth_byte      (window_bus[4]),
    .in_sixth_byte      (window_bus[5]),
    .out_valid          (out_valid),
    .out_form           (out_form),
    .out_to_register    (out_to_register),
    .out_wide           (out_wide),
    .out_mode           (out_mode),
    .out_register_field (out_register_field),
    .out_memory_field   (out_memory_field),
    .out_direct_address (out_direct_address),
    .out_displacement   (out_displacement),
    .out_immediate      (out_immediate),
    .out_length         (out_length)
  );

  // clock, period 2
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // decode one six-byte window the way the 8086 lays out these forms
  function automatic xmad_pkg::decode_t decode_window(input logic [5:0][7:0] b);
    xmad_pkg::decode_t d;
    logic [1:0] mode;
    logic [2:0] rm;
    logic       direct;
    logic [15:0] disp;
    logic [2:0] disp_len;
    logic [2:0] data_at;
    d = '0;
    mode = b[1][7:6];
    rm = b[1][2:0];
    direct = (mode == xmad_pkg::MOD_NO_DISP) && (rm == xmad_pkg::RM_DIRECT);
    disp = '0;
    disp_len = 3'd0;
    // disp8 is always sign-extended, direct address shares the disp16 layout
    if (mode == xmad_pkg::MOD_DISP8) begin
      disp = {{8{b[2][7]}}, b[2]};
      disp_len = 3'd1;
    end else if (mode == xmad_pkg::MOD_DISP16 || direct) begin
      disp = {b[3], b[2]};
      disp_len = 3'd2;
    end
    if ((b[0] & xmad_pkg::MASK_MOV_RM) == xmad_pkg::PAT_MOV_RM ||
        (b[0] & xmad_pkg::MASK_ADD_RM) == xmad_pkg::PAT_ADD_RM) begin
      d.form = ((b[0] & xmad_pkg::MASK_MOV_RM) == xmad_pkg::PAT_MOV_RM) ?
               xmad_pkg::FORM_MOV_RM : xmad_pkg::FORM_ADD_RM;
      d.to_register = b[0][1];
      d.wide = b[0][0];
      d.mode = mode;
      d.register_field = b[1][5:3];
      d.memory_field = rm;
      d.direct_address = direct;
      d.displacement = disp;
      d.length = 3'd2 + disp_len;
    end else if ((b[0] & xmad_pkg::MASK_MOV_IMM_RM) == xmad_pkg::PAT_MOV_IMM_RM) begin
      // data follows any displacement or direct address
      data_at = 3'd2 + disp_len;
      d.form = xmad_pkg::FORM_MOV_IMM_RM;
      d.wide = b[0][0];
      d.mode = mode;
      d.register_field = b[1][5:3];
      d.memory_field = rm;
      d.direct_address = direct;
      d.displacement = disp;
      d.immediate = {b[0][0] ? b[data_at + 3'd1] : 8'h00, b[data_at]};
      d.length = data_at + 3'd1 + {2'b00, b[0][0]};
    end else if ((b[0] & xmad_pkg::MASK_MOV_IMM_REG) == xmad_pkg::PAT_MOV_IMM_REG) begin
      d.form = xmad_pkg::FORM_MOV_IMM_REG;
      d.to_register = 1'b1;
      d.wide = b[0][3];
      d.register_field = b[0][2:0];
      d.immediate = {b[0][3] ? b[2] : 8'h00, b[1]};
      d.length = 3'd2 + {2'b00, b[0][3]};
    end else begin
      d.form = xmad_pkg::FORM_UNKNOWN;
    end
    return d;
  endfunction

  function automatic string show_decode(input xmad_pkg::decode_t d);
    return $sformatf({"form=%0d d=%0b w=%0b mod=%0d reg=%0d rm=%0d dir=%0b",
                      " disp=%h imm=%h len=%0d"},
                     d.form, d.to_register, d.wide, d.mode, d.register_field,
                     d.memory_field, d.direct_address, d.displacement, d.immediate,
                     d.length);
  endfunction

  task automatic note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch at %0t: %s", $time, msg);
  endtask

  // compare each decoded word against the oldest prediction
  always @(posedge clk) begin : check_results
    xmad_pkg::decode_t got;
    xmad_pkg::decode_t want;
    got = {out_form, out_to_register, out_wide, out_mode, out_register_field,
           out_memory_field, out_direct_address, out_displacement, out_immediate,
           out_length};
    if (rst_n === 1'b1 && $isunknown(out_valid)) begin
      note_failure("out_valid unknown");
    end else if (rst_n === 1'b1 && out_valid) begin
      if (expected_decodes.size() == 0) begin
        note_failure({"unexpected word: ", show_decode(got)});
      end else begin
        want = expected_decodes.pop_front();
        if (got.form !== want.form || got.to_register !== want.to_register ||
            got.wide !== want.wide || got.mode !== want.mode ||
            got.register_field !== want.register_field ||
            got.memory_field !== want.memory_field ||
            got.direct_address !== want.direct_address ||
            got.displacement !== want.displacement ||
            got.immediate !== want.immediate || got.length !== want.length) begin
          note_failure({"expected ", show_decode(want), " got ", show_decode(got)});
        end
      end
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  // present one window word, wait for it to be taken, then maybe idle
  task automatic send_window(input logic [7:0] b0, b1, b2, b3, b4, b5);
    int gap;
    start <= 1'b1;
    window_bus <= {b5, b4, b3, b2, b1, b0};
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_decodes.push_back(decode_window({b5, b4, b3, b2, b1, b0}));
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      // idle bytes carry noise that must be ignored
      start <= 1'b0;
      window_bus <= 48'({$urandom, $urandom});
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off the sender until every prediction has been matched
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (expected_decodes.size() != 0) @(posedge clk);
  endtask

  // mov r/m forms and add, every mod, extremes of displacement
  task automatic test_register_memory_moves();
    send_window(8'h89, 8'hD8, 8'h11, 8'h22, 8'h33, 8'h44);
    send_window(8'h8B, 8'h46, 8'h80, 8'h55, 8'h66, 8'h77);
    send_window(8'h88, 8'h47, 8'h7F, 8'h00, 8'h00, 8'h00);
    send_window(8'h8A, 8'h86, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_window(8'h8B, 8'h36, 8'h34, 8'h12, 8'h99, 8'h88);
    send_window(8'h8C, 8'h00, 8'hAA, 8'hBB, 8'hCC, 8'hDD);
    send_window(8'h8F, 8'h3F, 8'h00, 8'h80, 8'h01, 8'h02);
    send_window(8'h00, 8'h06, 8'hCD, 8'hAB, 8'hEE, 8'hFF);
    send_window(8'h03, 8'hFF, 8'h12, 8'h34, 8'h56, 8'h78);
    send_window(8'h01, 8'h40, 8'hF0, 8'h0F, 8'hF0, 8'h0F);
    send_window(8'h02, 8'hBF, 8'h00, 8'h80, 8'hFF, 8'h00);
  endtask

  // immediate forms, including the six-byte direct address case
  task automatic test_immediate_moves();
    send_window(8'hC7, 8'h06, 8'h34, 8'h12, 8'h78, 8'h56);
    send_window(8'hC6, 8'h06, 8'h00, 8'h80, 8'hAA, 8'hFF);
    send_window(8'hC7, 8'hC0, 8'hEF, 8'hBE, 8'h11, 8'h22);
    send_window(8'hC6, 8'hF8, 8'h55, 8'h66, 8'h77, 8'h88);
    send_window(8'hC7, 8'h45, 8'hFE, 8'h34, 8'h12, 8'hFF);
    send_window(8'hC6, 8'h86, 8'h00, 8'h01, 8'h99, 8'hFF);
    send_window(8'hB0, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_window(8'hBF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00);
    send_window(8'hB5, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A);
    send_window(8'hB8, 8'h34, 8'h12, 8'hFF, 8'hFF, 8'hFF);
  endtask

  // opcodes outside the four forms decode to form 4 with all other fields zero
  task automatic test_unknown_opcodes();
    send_window(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_window(8'h04, 8'h06, 8'h12, 8'h34, 8'h56, 8'h78);
    send_window(8'hC8, 8'hC0, 8'h01, 8'h02, 8'h03, 8'h04);
    send_window(8'hA0, 8'h86, 8'h80, 8'h80, 8'h80, 8'h80);
  endtask

  // random windows, mostly well-formed opcodes with random operand bytes
  task automatic test_random_windows(input int count);
    logic [7:0] op;
    int         kind;
    for (int i = 0; i < count; i++) begin
      // alternate stretches with and without idling
      if (i % 120 == 0) gaps_on = ($urandom_range(0, 2) != 0);
      if (i == count / 2) drain_results();
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1: op = {5'b10001, 3'($urandom)};
        2, 3: op = {7'b1100011, 1'($urandom)};
        4, 5: op = {4'b1011, 4'($urandom)};
        6, 7: op = {6'b000000, 2'($urandom)};
        default: op = 8'($urandom);
      endcase
      send_window(op, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom));
    end
    gaps_on = 1'b1;
  endtask

  // run limit
  initial begin
    #1000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // reset, then each test in turn
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_register_memory_moves();
    drain_results();
    test_immediate_moves();
    test_unknown_opcodes();
    drain_results();
    test_random_windows(1100);
    drain_results();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/xmad_pkg.sv
rtl/xmad_decode.sv
rtl/x86_16_mov_add_decoder_unit.sv
test/tb_top.sv
